@@ src/vmip_pkg.sv @@
// ----------------------------------------------------------------------------
// vmip_pkg: shared types and constants of the vector memory issue pipeline
// Item formats, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package vmip_pkg;

  localparam int READ_QUEUE_DEPTH_DEF = 16;
  localparam int MAX_ISSUE_WIDTH_DEF  = 4;
  localparam int MAX_INFLIGHT_DEF     = 64;
  localparam int MAX_RESULTS          = 64;
  localparam int MAX_LANES            = 64;

  localparam logic [6:0] INFLIGHT_LIMIT_RST   = 7'd32;
  localparam logic [2:0] ISSUE_WIDTH_RST      = 3'd1;
  localparam logic [3:0] REGISTER_LATENCY_RST = 4'd1;

  localparam logic [1:0] REG_INFLIGHT_LIMIT   = 2'd0;
  localparam logic [1:0] REG_ISSUE_WIDTH      = 2'd1;
  localparam logic [1:0] REG_REGISTER_LATENCY = 2'd2;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_CMP  = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_RETIRED  = 3'd0,
    EV_ISSUED   = 3'd1,
    EV_TO_EXEC  = 3'd2,
    EV_ENQUEUED = 3'd3,
    EV_FULL     = 3'd4,
    EV_UNKNOWN  = 3'd5
  } event_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tag;
    logic       is_write;
    logic [6:0] lane_count;
    logic [3:0] decode_wait;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] tag_res;
    logic       is_write_res;
    logic [6:0] lane_count_res;
    logic       last;
  } out_item_t;

  // Instruction as held in the queues and the table (lanes = remaining accesses).
  typedef struct packed {
    logic [7:0] tag;
    logic       wr;
    logic [6:0] lanes;
  } ent_t;

  typedef struct packed {
    kind_t      kind;
    ent_t       ent;
    logic [3:0] wait_cnt;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_CMP_RD,
    S_CMP_CHK,
    S_DEC,
    S_WB_RD,
    S_WB_CHK,
    S_EX,
    S_RD_REQ,
    S_RD_DO,
    S_FIN
  } state_t;

endpackage

@@ src/vmip_front.sv @@
// ----------------------------------------------------------------------------
// vmip_front: input decode and command queue
// Classifies incoming items, saturates the lane count and buffers commands
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module vmip_front import vmip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       known;
  logic       push;
  cmd_t       dec;

  assign in_ready = (count != 2'd2);

  always_comb begin
    known = 1'b1;
    dec.kind = KIND_ENQ;
    unique case (in_data.kind)
      KIND_ENQ:  dec.kind = KIND_ENQ;
      KIND_CMP:  dec.kind = KIND_CMP;
      KIND_TICK: dec.kind = KIND_TICK;
      default:   known = 1'b0;
    endcase
    dec.ent.tag   = in_data.tag;
    dec.ent.wr    = in_data.is_write;
    dec.ent.lanes = (32'(in_data.lane_count) > MAX_LANES) ? 7'(MAX_LANES)
                                                          : in_data.lane_count;
    dec.wait_cnt  = in_data.decode_wait;
  end

  // Unknown kinds are taken and dropped without a result.
  assign push      = in_valid && in_ready && known;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop && cmd_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop && cmd_valid);
    end
  end

endmodule

@@ src/vmip_back.sv @@
// ----------------------------------------------------------------------------
// vmip_back: pipeline state and sequencer
// Holds the read queue, execute queue and outstanding table, runs the
// enqueue, completion and tick operations step by step and emits results.
// ----------------------------------------------------------------------------
module vmip_back import vmip_pkg::*; #(
  parameter int READ_QUEUE_DEPTH = READ_QUEUE_DEPTH_DEF,
  parameter int MAX_ISSUE_WIDTH  = MAX_ISSUE_WIDTH_DEF,
  parameter int MAX_INFLIGHT     = MAX_INFLIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RQ_AW = $clog2(READ_QUEUE_DEPTH);
  localparam int RQ_CW = $clog2(READ_QUEUE_DEPTH + 1);
  localparam int EQ_AW = (MAX_ISSUE_WIDTH > 1) ? $clog2(MAX_ISSUE_WIDTH) : 1;
  localparam int IW_CW = $clog2(MAX_ISSUE_WIDTH + 1);
  localparam int OT_AW = (MAX_INFLIGHT > 1) ? $clog2(MAX_INFLIGHT) : 1;
  localparam int OT_CW = $clog2(MAX_INFLIGHT + 1);
  localparam int RC_W  = $clog2(MAX_RESULTS + 1);
  localparam int RET_CAP = MAX_RESULTS - 2 * MAX_ISSUE_WIDTH;

  typedef struct packed {
    ent_t       ent;
    logic [3:0] wait_cnt;
  } eq_ent_t;

  // configuration
  logic [6:0] inflight_limit;
  logic [2:0] issue_width;
  logic [3:0] register_latency;

  // sequencer
  state_t st, st_next;
  cmd_t   cur;
  logic [OT_CW-1:0] idx;
  logic [OT_CW-1:0] wk;
  logic [RC_W-1:0]  retired;
  logic [IW_CW-1:0] issued;

  // read queue: payload in memory, waits in per-slot counters
  ent_t             rq_mem [READ_QUEUE_DEPTH];
  ent_t             rq_rdata;
  logic [3:0]       rq_wait [READ_QUEUE_DEPTH];
  logic [READ_QUEUE_DEPTH-1:0] rq_zero;
  logic [RQ_AW-1:0] rq_head;
  logic [RQ_AW-1:0] rq_tail;
  logic [RQ_CW-1:0] rq_count;
  logic             rq_full;

  // execute queue: shift register, head at entry 0
  eq_ent_t          eq [MAX_ISSUE_WIDTH];
  logic [IW_CW-1:0] eq_count;

  // outstanding table
  ent_t             ot_mem [MAX_INFLIGHT];
  ent_t             ot_rdata;
  logic [OT_CW-1:0] ot_count;

  // result staging: held result waits until it is known whether it is last
  logic      hv;
  out_item_t hd;
  out_item_t hd_out;

  // strobes
  logic       emit;
  out_item_t  emit_item;
  logic       fin_push;
  logic       ot_we;
  logic [OT_AW-1:0] ot_waddr;
  ent_t       ot_wdata;
  logic       rq_we;

  logic [IW_CW-1:0] eff_width;
  logic [OT_CW-1:0] eff_limit;
  logic out_free, can_emit;
  logic scan_done, cmp_hit, wb_retire, ex_go, rd_go;

  always_comb begin
    if (issue_width == 3'd0)                     eff_width = IW_CW'(1);
    else if (32'(issue_width) >= MAX_ISSUE_WIDTH) eff_width = IW_CW'(MAX_ISSUE_WIDTH);
    else                                         eff_width = IW_CW'(issue_width);
    if (inflight_limit == 7'd0)                  eff_limit = OT_CW'(1);
    else if (32'(inflight_limit) >= MAX_INFLIGHT) eff_limit = OT_CW'(MAX_INFLIGHT);
    else                                         eff_limit = OT_CW'(inflight_limit);
  end

  for (genvar j = 0; j < READ_QUEUE_DEPTH; j++) begin : g_zero
    assign rq_zero[j] = (rq_wait[j] == 4'd0);
  end

  assign rq_full   = (rq_count == RQ_CW'(READ_QUEUE_DEPTH));
  assign out_free  = !out_valid || out_ready;
  assign can_emit  = !hv || out_free;
  assign scan_done = (idx >= ot_count);
  assign cmp_hit   = (ot_rdata.tag == cur.ent.tag) && (ot_rdata.lanes != 7'd0);
  assign wb_retire = (ot_rdata.lanes == 7'd0) && (32'(retired) < RET_CAP);
  assign ex_go     = (eq_count != '0) && (eq[0].wait_cnt == 4'd0) &&
                     (issued < eff_width) && (ot_count < eff_limit);
  assign rd_go     = (rq_count != '0) && rq_zero[rq_head] &&
                     (issued < eff_width) && (eq_count < eff_width);

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_ENQ:  st_next = S_ENQ;
            KIND_CMP:  st_next = S_CMP_RD;
            KIND_TICK: st_next = S_DEC;
            default:   st_next = S_IDLE;
          endcase
        end
      end
      S_ENQ:     if (can_emit) st_next = S_FIN;
      S_CMP_RD: begin
        if (!scan_done)    st_next = S_CMP_CHK;
        else if (can_emit) st_next = S_FIN;
      end
      S_CMP_CHK: st_next = cmp_hit ? S_FIN : S_CMP_RD;
      S_DEC:     st_next = S_WB_RD;
      S_WB_RD:   st_next = scan_done ? S_EX : S_WB_CHK;
      S_WB_CHK:  if (!wb_retire || can_emit) st_next = S_WB_RD;
      S_EX:      if (!ex_go) st_next = S_RD_REQ;
      S_RD_REQ:  st_next = rd_go ? S_RD_DO : S_FIN;
      S_RD_DO:   if (can_emit) st_next = S_RD_REQ;
      S_FIN:     if (!hv || out_free) st_next = S_IDLE;
      default:   st_next = S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    fin_push  = 1'b0;
    ot_we     = 1'b0;
    ot_waddr  = idx[OT_AW-1:0];
    ot_wdata  = ot_rdata;
    rq_we     = 1'b0;
    unique case (st)
      S_IDLE: cmd_pop = cmd_valid;
      S_ENQ: begin
        emit                   = can_emit;
        rq_we                  = can_emit && !rq_full;
        emit_item.event_res    = rq_full ? EV_FULL : EV_ENQUEUED;
        emit_item.tag_res      = cur.ent.tag;
        emit_item.is_write_res = cur.ent.wr;
      end
      S_CMP_RD: begin
        emit                = scan_done && can_emit;
        emit_item.event_res = EV_UNKNOWN;
        emit_item.tag_res   = cur.ent.tag;
      end
      S_CMP_CHK: begin
        ot_we          = cmp_hit;
        ot_wdata.lanes = ot_rdata.lanes - 7'd1;
      end
      S_WB_CHK: begin
        emit                   = wb_retire && can_emit;
        emit_item.event_res    = EV_RETIRED;
        emit_item.tag_res      = ot_rdata.tag;
        emit_item.is_write_res = ot_rdata.wr;
        // Kept entries are packed down toward the front of the table.
        ot_we                  = !wb_retire;
        ot_waddr               = wk[OT_AW-1:0];
      end
      S_EX: begin
        emit                     = ex_go && can_emit;
        emit_item.event_res      = EV_ISSUED;
        emit_item.tag_res        = eq[0].ent.tag;
        emit_item.is_write_res   = eq[0].ent.wr;
        emit_item.lane_count_res = eq[0].ent.lanes;
        ot_we                    = ex_go && can_emit;
        ot_waddr                 = ot_count[OT_AW-1:0];
        ot_wdata                 = eq[0].ent;
      end
      S_RD_DO: begin
        emit                   = can_emit;
        emit_item.event_res    = EV_TO_EXEC;
        emit_item.tag_res      = rq_rdata.tag;
        emit_item.is_write_res = rq_rdata.wr;
      end
      S_FIN: fin_push = hv && out_free;
      default: ;
    endcase
  end

  // The held result leaves with its last flag set only when the item ends.
  always_comb begin
    hd_out      = hd;
    hd_out.last = fin_push;
  end

  // memories
  always_ff @(posedge clk) begin
    if (rq_we) rq_mem[rq_tail] <= cur.ent;
    rq_rdata <= rq_mem[rq_head];
  end

  always_ff @(posedge clk) begin
    if (ot_we) ot_mem[ot_waddr] <= ot_wdata;
    ot_rdata <= ot_mem[idx[OT_AW-1:0]];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight_limit   <= INFLIGHT_LIMIT_RST;
      issue_width      <= ISSUE_WIDTH_RST;
      register_latency <= REGISTER_LATENCY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INFLIGHT_LIMIT:   inflight_limit   <= cfg_data;
        REG_ISSUE_WIDTH:      issue_width      <= cfg_data[2:0];
        REG_REGISTER_LATENCY: register_latency <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hv        <= 1'b0;
    end else begin
      if ((emit && hv) || fin_push) begin
        out_valid <= 1'b1;
        out_data  <= hd_out;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        hv <= 1'b1;
        hd <= emit_item;
      end else if (fin_push) begin
        hv <= 1'b0;
      end
    end
  end

  // sequencer state and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      rq_head  <= '0;
      rq_tail  <= '0;
      rq_count <= '0;
      eq_count <= '0;
      ot_count <= '0;
    end else begin
      st <= st_next;
      unique case (st)
        S_IDLE: begin
          if (cmd_valid) cur <= cmd;
          idx <= '0;
        end
        S_ENQ: begin
          if (rq_we) begin
            rq_wait[rq_tail] <= cur.wait_cnt;
            rq_tail  <= (32'(rq_tail) == READ_QUEUE_DEPTH - 1) ? '0 : rq_tail + 1'b1;
            rq_count <= rq_count + 1'b1;
          end
        end
        S_CMP_CHK: if (!cmp_hit) idx <= idx + 1'b1;
        S_DEC: begin
          for (int j = 0; j < READ_QUEUE_DEPTH; j++) begin
            if (rq_wait[j] != 4'd0) rq_wait[j] <= rq_wait[j] - 4'd1;
          end
          for (int j = 0; j < MAX_ISSUE_WIDTH; j++) begin
            if (eq[j].wait_cnt != 4'd0) eq[j].wait_cnt <= eq[j].wait_cnt - 4'd1;
          end
          idx     <= '0;
          wk      <= '0;
          retired <= '0;
        end
        S_WB_RD: begin
          if (scan_done) begin
            ot_count <= wk;
            issued   <= '0;
          end
        end
        S_WB_CHK: begin
          if (wb_retire) begin
            if (can_emit) begin
              retired <= retired + 1'b1;
              idx     <= idx + 1'b1;
            end
          end else begin
            wk  <= wk + 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_EX: begin
          if (!ex_go) begin
            issued <= '0;
          end else if (can_emit) begin
            ot_count <= ot_count + 1'b1;
            for (int j = 0; j < MAX_ISSUE_WIDTH - 1; j++) begin
              eq[j] <= eq[j + 1];
            end
            eq_count <= eq_count - 1'b1;
            issued   <= issued + 1'b1;
          end
        end
        S_RD_DO: begin
          if (can_emit) begin
            eq[eq_count[EQ_AW-1:0]].ent      <= rq_rdata;
            eq[eq_count[EQ_AW-1:0]].wait_cnt <= register_latency;
            eq_count <= eq_count + 1'b1;
            rq_head  <= (32'(rq_head) == READ_QUEUE_DEPTH - 1) ? '0 : rq_head + 1'b1;
            rq_count <= rq_count - 1'b1;
            issued   <= issued + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/vector_memory_issue_pipeline_core.sv @@
// ----------------------------------------------------------------------------
// vector_memory_issue_pipeline_core: vector memory instruction issue pipeline
// Read queue, execute queue and outstanding-access table driven by enqueue,
// completion and tick items.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Direction
//   in        in_valid, in_ready, in_data      item in (valid/ready)
//   out       out_valid, out_ready, out_data   result out (valid/ready)
//   cfg       cfg_wr_en, cfg_index, cfg_data   register write
//
// An enqueue writes the read queue unless it is full; a completion
// searches the table entry by entry. A tick updates the waits, scans the
// table to retire and pack entries, issues from the execute queue, then
// moves read-queue entries to the execute queue. Items pass a two-entry
// command queue, so until it is full the input keeps taking items while
// the back end works or the output stalls. Reset is synchronous and
// empties all queues and the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_memory_issue_pipeline_core import vmip_pkg::*; #(
  parameter int READ_QUEUE_DEPTH = READ_QUEUE_DEPTH_DEF,
  parameter int MAX_ISSUE_WIDTH  = MAX_ISSUE_WIDTH_DEF,
  parameter int MAX_INFLIGHT     = MAX_INFLIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  vmip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  vmip_back #(
    .READ_QUEUE_DEPTH (READ_QUEUE_DEPTH),
    .MAX_ISSUE_WIDTH  (MAX_ISSUE_WIDTH),
    .MAX_INFLIGHT     (MAX_INFLIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
